// File: sv/bvrs_pkg.sv
// Shared constants, command and port codes, and the queue word type for the
// bit-plane video block. No dependencies; every other file except bvrs_rsp_if and bvrs_ram imports it.
package bvrs_pkg;

  localparam int PLANE_BYTES   = 65536;
  localparam int SCREEN_WIDTH  = 640;
  localparam int TEXT_ROWS     = 25;
  localparam int INDIRECT_REGS = 18;

  localparam int COLS_PER_LINE = SCREEN_WIDTH / 8;
  localparam int TOTAL_LINES   = TEXT_ROWS * 16;
  localparam int SHOWN_LINES   = TEXT_ROWS * 9;

  localparam int PADDR_W   = $clog2(PLANE_BYTES);
  localparam int COL_W     = (COLS_PER_LINE > 1) ? $clog2(COLS_PER_LINE) : 1;
  localparam int LINE_W    = $clog2(TOTAL_LINES);
  localparam int SHOWN_W   = $clog2(SHOWN_LINES);
  localparam int IND_IDX_W = (INDIRECT_REGS > 1) ? $clog2(INDIRECT_REGS) : 1;
  localparam int PTR_W     = 5;
  localparam int LINE_SHIFT = 7;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [1:0] CMD_PORT_RD  = 2'd0;
  localparam logic [1:0] CMD_PORT_WR  = 2'd1;
  localparam logic [1:0] CMD_PLANE_WR = 2'd2;
  localparam logic [1:0] CMD_RENDER   = 2'd3;

  localparam logic [7:0] PORT_CTRL     = 8'hd8;
  localparam logic [7:0] PORT_CTRL_A   = 8'hd9;
  localparam logic [7:0] PORT_ADDR_LAT = 8'hda;
  localparam logic [7:0] PORT_CTRL_B   = 8'hdb;
  localparam logic [7:0] PORT_IND_PTR  = 8'hdc;
  localparam logic [7:0] PORT_IND_DATA = 8'hdd;

  localparam logic [1:0] PLANE_BLUE  = 2'd0;
  localparam logic [1:0] PLANE_RED   = 2'd1;
  localparam logic [1:0] PLANE_GREEN = 2'd2;

  // One queued word: either a port read result or eight pixels' worth of
  // already masked colour bytes with their screen position.
  typedef struct packed {
    logic               is_pixel;
    logic [7:0]         read_data;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
    logic [COL_W-1:0]   col;
    logic [7:0]         line;
    logic               last;
  } qent_t;

  // Write port shared by the three plane memories.
  typedef struct packed {
    logic [2:0]         we;
    logic [PADDR_W-1:0] addr;
    logic [7:0]         data;
  } plane_wr_t;

endpackage

// File: sv/bvrs_req_if.sv
// Request channel of the bit-plane video block: valid/ready plus one input word.
// Depends on bvrs_pkg for field widths.
interface bvrs_req_if;
  import bvrs_pkg::*;
  logic               valid;
  logic               ready;
  logic [1:0]         cmd;
  logic [7:0]         port_addr;
  logic [7:0]         write_data;
  logic [1:0]         plane_sel;
  logic [PADDR_W-1:0] plane_addr;

  modport source (output valid, cmd, port_addr, write_data, plane_sel, plane_addr,
                  input ready);
  modport sink   (input valid, cmd, port_addr, write_data, plane_sel, plane_addr,
                  output ready);
endinterface

// File: sv/bvrs_rsp_if.sv
// Result channel of the bit-plane video block: valid/ready plus one result word.
// Standalone; fixed field widths.
interface bvrs_rsp_if;
  logic        valid;
  logic        ready;
  logic [7:0]  read_data;
  logic        is_pixel;
  logic [23:0] pixel_color;
  logic [9:0]  pixel_x;
  logic [7:0]  pixel_y;
  logic        group_last;
  logic        frame_end;

  modport source (output valid, read_data, is_pixel, pixel_color, pixel_x, pixel_y,
                  group_last, frame_end, input ready);
  modport sink   (input valid, read_data, is_pixel, pixel_color, pixel_x, pixel_y,
                  group_last, frame_end, output ready);
endinterface

// File: sv/bitplane_video_regs_and_scanout.sv
// Top level of the bit-plane video block: front end, three plane RAMs, word
// queue and pixel back end. Depends on bvrs_pkg, the two channel interfaces,
// bvrs_ram, bvrs_front, bvrs_queue and bvrs_back.
//
//   channel | dir | handshake       | word
//   req     | in  | valid / ready   | cmd, port_addr, write_data, plane_sel, plane_addr
//   rsp     | out | valid / ready   | read_data, is_pixel, pixel_color, pixel_x,
//           |     |                 | pixel_y, group_last, frame_end
//
// A port read leaves one result through the plane-read stage, the queue and the
// output register; a render leaves eight pixels, one per cycle while rsp.ready
// allows, through the single pixel output stage.
// Writes produce no result and are taken back to back while req.ready stays high.
// A four-word queue sits between the front end and the back end; req.ready
// drops once the queued words plus the one in the plane-read stage reach four.
// Reset is synchronous; the plane memories are not cleared.
module bitplane_video_regs_and_scanout (
  input  logic        clk,
  input  logic        rst,
  bvrs_req_if.sink    req,
  bvrs_rsp_if.source  rsp
);
  import bvrs_pkg::*;

  logic [QCNT_W-1:0]  q_count;
  logic               push;
  logic               pop;
  qent_t              push_data;
  qent_t              head;
  plane_wr_t          plane_wr;
  logic [PADDR_W-1:0] plane_raddr;
  logic [7:0]         blue_rd;
  logic [7:0]         red_rd;
  logic [7:0]         green_rd;

  bvrs_front u_front (
    .clk         (clk),
    .rst         (rst),
    .req         (req),
    .q_count     (q_count),
    .push        (push),
    .push_data   (push_data),
    .plane_wr    (plane_wr),
    .plane_raddr (plane_raddr),
    .blue_rd     (blue_rd),
    .red_rd      (red_rd),
    .green_rd    (green_rd)
  );

  bvrs_ram #(.WIDTH(8), .DEPTH(PLANE_BYTES)) u_blue (
    .clk   (clk),
    .we    (plane_wr.we[0]),
    .waddr (plane_wr.addr),
    .wdata (plane_wr.data),
    .raddr (plane_raddr),
    .rdata (blue_rd)
  );

  bvrs_ram #(.WIDTH(8), .DEPTH(PLANE_BYTES)) u_red (
    .clk   (clk),
    .we    (plane_wr.we[1]),
    .waddr (plane_wr.addr),
    .wdata (plane_wr.data),
    .raddr (plane_raddr),
    .rdata (red_rd)
  );

  bvrs_ram #(.WIDTH(8), .DEPTH(PLANE_BYTES)) u_green (
    .clk   (clk),
    .we    (plane_wr.we[2]),
    .waddr (plane_wr.addr),
    .wdata (plane_wr.data),
    .raddr (plane_raddr),
    .rdata (green_rd)
  );

  bvrs_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .count     (q_count),
    .head      (head)
  );

  bvrs_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_count (q_count),
    .head    (head),
    .pop     (pop),
    .rsp     (rsp)
  );

endmodule

// File: sv/bvrs_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bvrs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: sv/bvrs_front.sv
// Front end: accepts request words, owns the port registers and the scan
// position, drives the plane memories and pushes read/render words to the queue.
// Depends on bvrs_pkg and bvrs_req_if.
module bvrs_front (
  input  logic                        clk,
  input  logic                        rst,
  bvrs_req_if.sink                    req,
  input  logic [bvrs_pkg::QCNT_W-1:0] q_count,
  output logic                        push,
  output bvrs_pkg::qent_t             push_data,
  output bvrs_pkg::plane_wr_t         plane_wr,
  output logic [bvrs_pkg::PADDR_W-1:0] plane_raddr,
  input  logic [7:0]                  blue_rd,
  input  logic [7:0]                  red_rd,
  input  logic [7:0]                  green_rd
);
  import bvrs_pkg::*;

  logic accept;

  // Port registers.
  logic [7:0]       control_byte;
  logic [2:0]       colour_enables;
  logic             flash_on;
  logic [3:0]       copy_mem_flags;
  logic [7:0]       control_a;
  logic [7:0]       addr_latch;
  logic [7:0]       control_b;
  logic [PTR_W-1:0] ind_ptr;
  logic [7:0]       ind_file [INDIRECT_REGS];
  logic             ind_ok;
  logic [7:0]       port_rdata;

  // Scan position.
  logic [LINE_W-1:0]  scan_line;
  logic [COL_W-1:0]   column;
  logic [SHOWN_W-1:0] shown_line;
  logic [LINE_W-1:0]  scan_line_next;
  logic [COL_W-1:0]   column_next;
  logic [SHOWN_W-1:0] shown_line_next;
  logic [LINE_W:0]    scan_inc;
  logic               line_end;
  logic               frame_last;

  // Stage holding a word while the plane read completes.
  logic               s1_valid;
  logic               s1_pix;
  logic [7:0]         s1_rdata;
  logic [2:0]         s1_en;
  logic               s1_flash;
  logic [COL_W-1:0]   s1_col;
  logic [7:0]         s1_line;
  logic               s1_last;

  // Room is reserved for the staged word as well as the new one.
  assign req.ready = (32'(q_count) + 32'(s1_valid)) < QUEUE_DEPTH;
  assign accept    = req.valid && req.ready;

  assign ind_ok = 32'(ind_ptr) < INDIRECT_REGS;

  always_comb begin
    case (req.port_addr)
      PORT_CTRL:     port_rdata = control_byte;
      PORT_CTRL_A:   port_rdata = control_a;
      PORT_ADDR_LAT: port_rdata = addr_latch;
      PORT_CTRL_B:   port_rdata = control_b;
      PORT_IND_PTR:  port_rdata = 8'(ind_ptr);
      PORT_IND_DATA: port_rdata = ind_ok ? ind_file[ind_ptr[IND_IDX_W-1:0]] : 8'd0;
      default:       port_rdata = 8'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      control_byte   <= 8'd0;
      colour_enables <= 3'b111;
      flash_on       <= 1'b0;
      copy_mem_flags <= 4'd0;
      control_a      <= 8'd0;
      addr_latch     <= 8'd0;
      control_b      <= 8'd0;
      ind_ptr        <= '0;
      for (int i = 0; i < INDIRECT_REGS; i++) begin
        ind_file[i] <= 8'd0;
      end
    end else if (accept && req.cmd == CMD_PORT_WR) begin
      case (req.port_addr)
        PORT_CTRL: begin
          control_byte   <= req.write_data;
          colour_enables <= ~req.write_data[2:0];
          flash_on       <= ~req.write_data[3];
          copy_mem_flags <= ~req.write_data[7:4];
        end
        PORT_CTRL_A:   control_a  <= req.write_data;
        PORT_ADDR_LAT: addr_latch <= req.write_data;
        PORT_CTRL_B:   control_b  <= req.write_data;
        PORT_IND_PTR: begin
          if (32'(req.write_data) < INDIRECT_REGS) begin
            ind_ptr <= PTR_W'(req.write_data);
          end
        end
        PORT_IND_DATA: begin
          if (ind_ok) begin
            ind_file[ind_ptr[IND_IDX_W-1:0]] <= req.write_data;
          end
        end
        default: ;
      endcase
    end
  end

  // Plane writes go straight to memory; the copy flags and the address latch
  // are only stored, and the latch contributes nothing to the scan address.
  always_comb begin
    plane_wr.we   = 3'b000;
    plane_wr.addr = req.plane_addr;
    plane_wr.data = req.write_data;
    if (accept && req.cmd == CMD_PLANE_WR) begin
      case (req.plane_sel)
        PLANE_BLUE:  plane_wr.we = 3'b001;
        PLANE_RED:   plane_wr.we = 3'b010;
        PLANE_GREEN: plane_wr.we = 3'b100;
        default:     plane_wr.we = 3'b000;
      endcase
    end
  end

  assign plane_raddr = PADDR_W'((32'(scan_line) << LINE_SHIFT) + 32'(column));

  assign line_end   = 32'(column) + 1 >= COLS_PER_LINE;
  assign frame_last = line_end && (32'(shown_line) + 1 >= SHOWN_LINES);

  // Lines whose low nibble reaches 9 are blanked, so the count skips ahead
  // to the next multiple of sixteen.
  always_comb begin
    scan_inc = {1'b0, scan_line} + 1'b1;
    if (scan_inc[3:0] >= 4'd9) begin
      scan_inc = {scan_inc[LINE_W:4] + 1'b1, 4'b0000};
    end
    column_next     = column + 1'b1;
    scan_line_next  = scan_line;
    shown_line_next = shown_line;
    if (line_end) begin
      column_next = '0;
      if (32'(scan_inc) >= TOTAL_LINES) begin
        scan_line_next  = '0;
        shown_line_next = '0;
      end else begin
        scan_line_next  = scan_inc[LINE_W-1:0];
        shown_line_next = shown_line + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_line  <= '0;
      column     <= '0;
      shown_line <= '0;
    end else if (accept && req.cmd == CMD_RENDER) begin
      scan_line  <= scan_line_next;
      column     <= column_next;
      shown_line <= shown_line_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept && (req.cmd == CMD_PORT_RD || req.cmd == CMD_RENDER);
    end
  end

  always_ff @(posedge clk) begin
    s1_pix   <= req.cmd == CMD_RENDER;
    s1_rdata <= port_rdata;
    s1_en    <= colour_enables;
    s1_flash <= flash_on;
    s1_col   <= column;
    s1_line  <= 8'(shown_line);
    s1_last  <= frame_last;
  end

  assign push = s1_valid;

  always_comb begin
    push_data.is_pixel  = s1_pix;
    push_data.read_data = s1_pix ? 8'd0 : s1_rdata;
    push_data.red       = s1_flash ? 8'hff : (s1_en[0] ? red_rd : 8'd0);
    push_data.green     = s1_flash ? 8'hff : (s1_en[1] ? green_rd : 8'd0);
    push_data.blue      = s1_flash ? 8'hff : (s1_en[2] ? blue_rd : 8'd0);
    push_data.col       = s1_col;
    push_data.line      = s1_line;
    push_data.last      = s1_last;
  end

  // The blanked part of each sixteen-line group is never a scan position.
  a_scan_shown: assert property (@(posedge clk) disable iff (rst)
    scan_line[3:0] < 4'd9)
    else $error("scan line sits in a blanked row");

  // The indirect pointer is only ever loaded with an in-range index.
  a_ptr_range: assert property (@(posedge clk) disable iff (rst) ind_ok)
    else $error("indirect pointer out of range");

endmodule

// File: sv/bvrs_queue.sv
// Short FIFO of queue words between the front end and the pixel back end.
// Depends on bvrs_pkg.
module bvrs_queue (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  input  bvrs_pkg::qent_t             push_data,
  input  logic                        pop,
  output logic [bvrs_pkg::QCNT_W-1:0] count,
  output bvrs_pkg::qent_t             head
);
  import bvrs_pkg::*;

  qent_t             ent [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;

  assign head = ent[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      ent[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (32'(count) < QUEUE_DEPTH))
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> (count != '0))
    else $error("queue read while empty");

endmodule

// File: sv/bvrs_back.sv
// Back end: expands each queue word into one read result or eight pixels,
// one per cycle while the output stage is empty or rsp.ready is high, into a registered output stage.
// Depends on bvrs_pkg and bvrs_rsp_if.
module bvrs_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [bvrs_pkg::QCNT_W-1:0] q_count,
  input  bvrs_pkg::qent_t             head,
  output logic                        pop,
  bvrs_rsp_if.source                  rsp
);
  import bvrs_pkg::*;

  logic       q_valid;
  logic       out_free;
  logic       emit;
  logic [2:0] pix_idx;
  logic [2:0] bit_pos;

  assign q_valid  = q_count != '0;
  assign out_free = !rsp.valid || rsp.ready;
  assign emit     = q_valid && out_free;
  assign pop      = emit && (!head.is_pixel || pix_idx == 3'd7);
  // Leftmost pixel comes from the most significant bit.
  assign bit_pos  = ~pix_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      pix_idx   <= 3'd0;
      rsp.valid <= 1'b0;
    end else begin
      if (out_free) begin
        rsp.valid <= q_valid;
      end
      if (pop) begin
        pix_idx <= 3'd0;
      end else if (emit) begin
        pix_idx <= pix_idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      rsp.read_data <= head.read_data;
      rsp.is_pixel  <= head.is_pixel;
      if (head.is_pixel) begin
        rsp.pixel_color <= {{8{head.red[bit_pos]}}, {8{head.green[bit_pos]}},
                            {8{head.blue[bit_pos]}}};
        rsp.pixel_x     <= 10'((32'(head.col) << 3) + 32'(pix_idx));
        rsp.pixel_y     <= head.line;
        rsp.group_last  <= pix_idx == 3'd7;
        rsp.frame_end   <= (pix_idx == 3'd7) && head.last;
      end else begin
        rsp.pixel_color <= 24'd0;
        rsp.pixel_x     <= 10'd0;
        rsp.pixel_y     <= 8'd0;
        rsp.group_last  <= 1'b0;
        rsp.frame_end   <= 1'b0;
      end
    end
  end

  // A partly sent pixel group keeps its queue word at the head.
  a_group_held: assert property (@(posedge clk) disable iff (rst)
    (pix_idx != 3'd0) |-> (q_valid && head.is_pixel))
    else $error("pixel group lost its queue word");

  a_frame_end_last: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.frame_end) |-> (rsp.group_last && rsp.is_pixel))
    else $error("frame end outside a group's last pixel");

endmodule
